[rtl/tdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants and controller/datapath interface types for the
// trial division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // capture a new number, set divisor to 3
        logic start_div;  // start a remainder computation
        logic div_step;   // one restoring division step
        logic next_div;   // advance to the next odd divisor
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic neg;        // number is negative
        logic lt2;        // magnitude below 2
        logic lt4;        // magnitude below 4
        logic even;       // magnitude is even
        logic sq_gt;      // divisor squared exceeds the number
        logic rem_zero;   // remainder is zero
        logic div_last;   // final division step this cycle
    } status_t;

endpackage
`default_nettype wire

[rtl/trial_division_prime_test_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Trial division primality test over a signed DATA_WIDTH-bit number.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer carries one signed number in
//   s_tdata[DATA_WIDTH-1:0] (upper pad bits ignored). s_tready is high only
//   while the block is idle; one number is worked at a time.
//   Output stream m_*: one transfer per number, m_tdata[0] = is_prime.
//   Values below 2 (including every negative value) report 0.
// Sequence:
//   Accept, then classify; small and even values finish there.
//   Odd values then test odd divisors 3, 5, 7, ... while d*d <= n. Each
//   divisor takes a compare, DATA_WIDTH-1 steps of the bit-serial
//   remainder unit, and a zero test. The verdict then loads the output register.
// Stall:
//   The result sits in an output register; the next number is accepted
//   while it waits. A finished verdict waits for that register to drain.
// Reset: rst_n (async, active low) returns to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top #(
    parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [DATA_WIDTH-1:0] number
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [7:0]                                 m_tdata   // [0] is_prime
);

    tdp_pkg::cmd_t    cmd;
    tdp_pkg::status_t status;
    logic             is_prime;

    tdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .is_prime (is_prime),
        .cmd      (cmd),
        .status   (status)
    );

    tdp_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (s_tdata[DATA_WIDTH-1:0]),
        .cmd    (cmd),
        .status (status)
    );

    assign m_tdata = {7'b0, is_prime};

endmodule
`default_nettype wire

[rtl/tdp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_datapath
// Number, odd divisor, running square and bit-serial remainder unit.
// ----------------------------------------------------------------------------
module tdp_datapath #(
    parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [DATA_WIDTH-1:0] number,
    input  wire tdp_pkg::cmd_t         cmd,
    output tdp_pkg::status_t           status
);

    localparam int M     = DATA_WIDTH - 1;     // magnitude width
    localparam int CNT_W = $clog2(M + 1);

    logic [M-1:0]     n_reg;
    logic             neg_reg;
    logic [M-1:0]     d_reg;
    logic [M:0]       sq_reg;      // d_reg * d_reg, kept by increments
    logic [M-1:0]     dvd_reg;
    logic [M-1:0]     rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [M:0]       trial;
    logic             trial_ge;
    logic [M:0]       trial_sub;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign trial     = {rem_reg, dvd_reg[M-1]};
    assign trial_ge  = trial >= {1'b0, d_reg};
    assign trial_sub = trial - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= number[M-1:0];
            neg_reg <= number[DATA_WIDTH-1];
            d_reg   <= M'(3);
            sq_reg  <= (M + 1)'(9);
        end
        if (cmd.start_div)
        begin
            dvd_reg <= n_reg;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(M);
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[M-2:0], 1'b0};
            rem_reg <= trial_ge ? trial_sub[M-1:0] : trial[M-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.next_div)
        begin
            // (d+2)^2 = d^2 + 4d + 4
            d_reg  <= d_reg + M'(2);
            sq_reg <= sq_reg + (M + 1)'({d_reg, 2'b00}) + (M + 1)'(4);
        end
    end

    always_comb
    begin
        status.neg      = neg_reg;
        status.lt2      = n_reg < M'(2);
        status.lt4      = n_reg < M'(4);
        status.even     = ~n_reg[0];
        status.sq_gt    = sq_reg > {1'b0, n_reg};
        status.rem_zero = rem_reg == '0;
        status.div_last = cnt_reg == CNT_W'(1);
    end

    // partial remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> rem_reg < d_reg)
        else $error("remainder not below divisor");

endmodule
`default_nettype wire

[rtl/tdp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_ctrl
// Sequencer for the divisor search and the output register.
// ----------------------------------------------------------------------------
module tdp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic               is_prime,
    output tdp_pkg::cmd_t      cmd,
    input  wire tdp_pkg::status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_CHECK,
        ST_DIV,
        ST_TEST,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   res_reg, res_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   is_prime_reg, is_prime_next;
    logic   out_load;

    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        is_prime_next = is_prime_reg;
        out_load      = 1'b0;
        cmd           = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (status.neg || status.lt2 || (status.even && !status.lt4))
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (status.lt4)
                begin
                    res_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.sq_gt)
                begin
                    res_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.rem_zero)
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_RESULT:
            begin
                // wait for the output register to be free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    is_prime_next = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            is_prime_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_reg      <= res_next;
            m_tvalid_reg <= m_tvalid_next;
            is_prime_reg <= is_prime_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign is_prime = is_prime_reg;

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

    // an accepted number is classified next
    a_accept_classify: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CLASSIFY))
        else $error("accept not followed by classify");

    // a negative number never produces a prime verdict
    a_neg_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(status.neg && res_reg))
        else $error("negative number reported prime");

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the trial division prime test. Directed numbers cover
// values below two, small primes and prime squares, and the ends of the
// signed range. A random mix follows, with idle gaps on both streams, a long
// output stall and drain pauses. Every verdict is checked against a
// trial-division predictor in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_W       = tdp_pkg::DATA_WIDTH_DEF;
    localparam int S_TDATA_W   = ((NUM_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int RANDOM_ITEMS = 116;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [NUM_W-1:0] number
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;         // [0] is_prime, [7:1] zero

    bit   pending_verdicts[$];   // expected is_prime, oldest first
    int   error_count = 0;
    int   cycle_count = 0;
    bit   quiet       = 1'b0;    // no idling on either stream
    int   long_hold   = 0;       // cycles the receiver still holds off
    int   stall_left  = 0;

    trial_division_prime_test_top #(
        .DATA_WIDTH(NUM_W)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 clk = ~clk;

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("trial_division_prime_test_top regression: fail");
            $finish;
        end
    end

    // Trial division on the signed value: below two is never prime.
    function automatic bit predict_is_prime(logic [NUM_W-1:0] raw);
        longint unsigned mag;
        longint unsigned div;
        bit              verdict;
        if (raw[NUM_W-1])
            return 1'b0;
        mag = longint'(raw);
        if (mag < 2)
            return 1'b0;
        if (mag < 4)
            return 1'b1;
        if (mag[0] == 1'b0)
            return 1'b0;
        verdict = 1'b1;
        for (div = 3; div * div <= mag; div += 2)
        begin
            if (mag % div == 0)
            begin
                verdict = 1'b0;
                break;
            end
        end
        return verdict;
    endfunction

    // Mostly short gaps, a few long ones; none in quiet stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (long_hold > 0)
        begin
            m_tready <= 1'b0;
            long_hold--;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Result check. Sampled at the falling edge, where the handshake is stable;
    // the transfer completes at the next rising edge.
    always @(negedge clk)
    begin
        bit want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result transfer: is_prime=%0b", m_tdata[0]);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want)
                begin
                    $error("is_prime: expected %0b, actual %0b", want, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[7:1] !== 7'd0)
                begin
                    $error("m_tdata pad: expected 0, actual %0h", m_tdata[7:1]);
                    error_count++;
                end
            end
        end
    end

    // One input transfer. Called just after a rising edge; returns just after
    // the edge that completed the transfer, with s_tvalid still high.
    task automatic send_number(input logic [NUM_W-1:0] number);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(number);
        forever
        begin
            @(negedge clk);
            if (s_tready)
            begin
                pending_verdicts.push_back(predict_is_prime(number));
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    // Sender stops and waits for every verdict to come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_below_two();
        send_number(32'h8000_0000);   // most negative
        send_number(32'hFFFF_FFFF);   // minus one
        send_number(-32'sd7);         // negative of a prime
        send_number(32'd0);
        send_number(32'd1);
        wait_drain();
    endtask

    // Two, three and five, the first even composite, prime squares where the
    // divisor loop must run exactly up to the square root, and a 16-bit prime.
    task automatic test_small_values();
        send_number(32'd2);
        send_number(32'd3);
        send_number(32'd4);
        send_number(32'd5);
        send_number(32'd9);
        send_number(32'd25);
        send_number(32'd49);
        send_number(32'd63001);       // 251 squared
        send_number(32'd65521);       // largest 16-bit prime
        wait_drain();
    endtask

    // Top of the positive range; the largest value is prime and is the
    // slowest item of the run.
    task automatic test_field_extremes();
        send_number(32'd16752649);    // 4093 squared
        send_number(32'h7FFF_FFFE);
        send_number(32'h7FFF_FFFD);
        send_number(32'h7FFF_FFFF);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering quick numbers, so
    // the output register fills and the input stalls.
    task automatic test_output_backpressure();
        quiet     = 1'b1;
        long_hold = 300;
        for (int i = 0; i < 6; i++)
            send_number($urandom_range(0, 40));
        wait_drain();
        quiet = 1'b0;
    endtask

    function automatic logic [NUM_W-1:0] random_number();
        int          roll;
        int unsigned factor;
        int unsigned quot;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return $urandom_range(0, 1023);
        if (roll < 55)
            return $urandom_range(1024, 65535);
        if (roll < 60)
            return $urandom_range(65536, 1 << 20);
        if (roll < 75)
            return $urandom() | 32'h8000_0000;
        if (roll < 87)
            return $urandom() & 32'h7FFF_FFFE;
        // large odd composite with a small factor: fast to refute
        factor = 3 + 2 * $urandom_range(0, 2);
        quot   = $urandom_range(1, 32'h7FFF_FFFF / factor - 1) | 1;
        return factor * quot;
    endfunction

    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= 60 && i < 80);
            send_number(random_number());
            if (i == 100)
                wait_drain();
        end
        quiet = 1'b0;
        wait_drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_below_two();
        test_small_values();
        test_field_extremes();
        test_output_backpressure();
        test_random_mix();

        repeat (60) @(posedge clk);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("trial_division_prime_test_top regression: pass");
        else
            $display("trial_division_prime_test_top regression: fail");
        $finish;
    end

endmodule
